// ===== design/mpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared types, instruction ids and opcode/funct tables for the primary and
// SPECIAL instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mpsd_pkg;

    localparam int WORD_W = 32;
    localparam int ID_W   = 7;
    localparam int FLD_W  = 6;
    localparam int REG_W  = 5;

    localparam logic [ID_W-1:0] ID_INVALID = 7'd0;
    localparam logic [ID_W-1:0] ID_BEQ     = 7'd3;
    localparam logic [ID_W-1:0] ID_BNE     = 7'd4;
    localparam logic [ID_W-1:0] ID_JALR    = 7'd61;
    localparam logic [ID_W-1:0] ID_SUBU    = 7'd85;
    localparam logic [ID_W-1:0] ID_OR      = 7'd87;
    localparam logic [ID_W-1:0] ID_NOR     = 7'd89;
    localparam logic [ID_W-1:0] ID_B       = 7'd108;
    localparam logic [ID_W-1:0] ID_BEQZ    = 7'd109;
    localparam logic [ID_W-1:0] ID_BNEZ    = 7'd110;
    localparam logic [ID_W-1:0] ID_NOP     = 7'd111;
    localparam logic [ID_W-1:0] ID_MOVE    = 7'd112;
    localparam logic [ID_W-1:0] ID_NOT     = 7'd113;
    localparam logic [ID_W-1:0] ID_NEGU    = 7'd114;
    localparam logic [ID_W-1:0] ID_MAX     = ID_NEGU;

    localparam logic [FLD_W-1:0] OPC_SPECIAL = 6'd0;
    localparam logic [REG_W-1:0] REG_ZERO    = 5'd0;
    localparam logic [REG_W-1:0] REG_RA      = 5'd31;

    typedef struct packed {
        logic [ID_W-1:0] instr_id;
        logic            is_valid;
        logic            alt_form;
    } dec_result_t;

    function automatic logic [ID_W-1:0] primary_id(input logic [FLD_W-1:0] opc);
        logic [ID_W-1:0] id;
        case (opc)
            6'd2:  id = 7'd1;
            6'd3:  id = 7'd2;
            6'd4:  id = 7'd3;
            6'd5:  id = 7'd4;
            6'd6:  id = 7'd5;
            6'd7:  id = 7'd6;
            6'd8:  id = 7'd7;
            6'd9:  id = 7'd8;
            6'd10: id = 7'd9;
            6'd11: id = 7'd10;
            6'd12: id = 7'd11;
            6'd13: id = 7'd12;
            6'd14: id = 7'd13;
            6'd15: id = 7'd14;
            6'd20: id = 7'd15;
            6'd21: id = 7'd16;
            6'd22: id = 7'd17;
            6'd23: id = 7'd18;
            6'd24: id = 7'd19;
            6'd25: id = 7'd20;
            6'd26: id = 7'd21;
            6'd27: id = 7'd22;
            6'd32: id = 7'd23;
            6'd33: id = 7'd24;
            6'd34: id = 7'd25;
            6'd35: id = 7'd26;
            6'd36: id = 7'd27;
            6'd37: id = 7'd28;
            6'd38: id = 7'd29;
            6'd39: id = 7'd30;
            6'd40: id = 7'd31;
            6'd41: id = 7'd32;
            6'd42: id = 7'd33;
            6'd43: id = 7'd34;
            6'd44: id = 7'd35;
            6'd45: id = 7'd36;
            6'd46: id = 7'd37;
            6'd47: id = 7'd38;
            6'd48: id = 7'd39;
            6'd49: id = 7'd40;
            6'd50: id = 7'd41;
            6'd51: id = 7'd42;
            6'd52: id = 7'd43;
            6'd53: id = 7'd44;
            6'd54: id = 7'd45;
            6'd55: id = 7'd46;
            6'd56: id = 7'd47;
            6'd57: id = 7'd48;
            6'd58: id = 7'd49;
            6'd60: id = 7'd50;
            6'd61: id = 7'd51;
            6'd62: id = 7'd52;
            6'd63: id = 7'd53;
            default: id = ID_INVALID;
        endcase
        return id;
    endfunction

    function automatic logic [ID_W-1:0] special_id(input logic [FLD_W-1:0] fn);
        logic [ID_W-1:0] id;
        case (fn)
            6'd0:  id = 7'd54;
            6'd2:  id = 7'd55;
            6'd3:  id = 7'd56;
            6'd4:  id = 7'd57;
            6'd6:  id = 7'd58;
            6'd7:  id = 7'd59;
            6'd8:  id = 7'd60;
            6'd9:  id = 7'd61;
            6'd10: id = 7'd62;
            6'd11: id = 7'd63;
            6'd12: id = 7'd64;
            6'd13: id = 7'd65;
            6'd15: id = 7'd66;
            6'd16: id = 7'd67;
            6'd17: id = 7'd68;
            6'd18: id = 7'd69;
            6'd19: id = 7'd70;
            6'd20: id = 7'd71;
            6'd22: id = 7'd72;
            6'd23: id = 7'd73;
            6'd24: id = 7'd74;
            6'd25: id = 7'd75;
            6'd26: id = 7'd76;
            6'd27: id = 7'd77;
            6'd28: id = 7'd78;
            6'd29: id = 7'd79;
            6'd30: id = 7'd80;
            6'd31: id = 7'd81;
            6'd32: id = 7'd82;
            6'd33: id = 7'd83;
            6'd34: id = 7'd84;
            6'd35: id = 7'd85;
            6'd36: id = 7'd86;
            6'd37: id = 7'd87;
            6'd38: id = 7'd88;
            6'd39: id = 7'd89;
            6'd42: id = 7'd90;
            6'd43: id = 7'd91;
            6'd44: id = 7'd92;
            6'd45: id = 7'd93;
            6'd46: id = 7'd94;
            6'd47: id = 7'd95;
            6'd48: id = 7'd96;
            6'd49: id = 7'd97;
            6'd50: id = 7'd98;
            6'd51: id = 7'd99;
            6'd52: id = 7'd100;
            6'd54: id = 7'd101;
            6'd56: id = 7'd102;
            6'd58: id = 7'd103;
            6'd59: id = 7'd104;
            6'd60: id = 7'd105;
            6'd62: id = 7'd106;
            6'd63: id = 7'd107;
            default: id = ID_INVALID;
        endcase
        return id;
    endfunction

endpackage

`default_nettype wire

// ===== design/mpsd_decode.sv =====
// ----------------------------------------------------------------------------
// mpsd_decode
// Combinational decode of one instruction word: table lookup on opcode or
// funct, pseudo-form rewrites and the jalr alternate-link flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsd_decode (
    input  wire logic [mpsd_pkg::WORD_W-1:0] instr_word,
    output mpsd_pkg::dec_result_t             result
);

    logic [mpsd_pkg::FLD_W-1:0] opc;
    logic [mpsd_pkg::FLD_W-1:0] fn;
    logic [mpsd_pkg::REG_W-1:0] rs;
    logic [mpsd_pkg::REG_W-1:0] rt;
    logic [mpsd_pkg::REG_W-1:0] rd;
    logic [mpsd_pkg::ID_W-1:0]  pri_id;
    logic [mpsd_pkg::ID_W-1:0]  spc_id;
    logic [mpsd_pkg::ID_W-1:0]  id;

    assign opc = instr_word[31:26];
    assign rs  = instr_word[25:21];
    assign rt  = instr_word[20:16];
    assign rd  = instr_word[15:11];
    assign fn  = instr_word[5:0];

    assign pri_id = mpsd_pkg::primary_id(opc);
    assign spc_id = mpsd_pkg::special_id(fn);

    always_comb begin
        if (opc == mpsd_pkg::OPC_SPECIAL) begin
            id = spc_id;
            if (instr_word == '0) begin
                id = mpsd_pkg::ID_NOP;
            end else if (rt == mpsd_pkg::REG_ZERO) begin
                if (spc_id == mpsd_pkg::ID_OR) begin
                    id = mpsd_pkg::ID_MOVE;
                end else if (spc_id == mpsd_pkg::ID_NOR) begin
                    id = mpsd_pkg::ID_NOT;
                end
            end else if (spc_id == mpsd_pkg::ID_SUBU && rs == mpsd_pkg::REG_ZERO) begin
                id = mpsd_pkg::ID_NEGU;
            end
        end else begin
            id = pri_id;
            if (rt == mpsd_pkg::REG_ZERO) begin
                if (pri_id == mpsd_pkg::ID_BEQ) begin
                    id = (rs == mpsd_pkg::REG_ZERO) ? mpsd_pkg::ID_B : mpsd_pkg::ID_BEQZ;
                end else if (pri_id == mpsd_pkg::ID_BNE) begin
                    id = mpsd_pkg::ID_BNEZ;
                end
            end
        end
    end

    assign result.instr_id = id;
    assign result.is_valid = (id != mpsd_pkg::ID_INVALID);
    assign result.alt_form = (id == mpsd_pkg::ID_JALR) && (rd != mpsd_pkg::REG_RA);

endmodule

`default_nettype wire

// ===== design/mips_primary_and_special_decode_core.sv =====
// ----------------------------------------------------------------------------
// mips_primary_and_special_decode_core
// Primary/SPECIAL MIPS instruction decoder with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one 32-bit instruction word per item; m_* channel
//   returns one result per item: dense id, valid flag and jalr alt-link flag.
//   Two register stages: word register, then result register. m_valid rises
//   once an accepted item has moved from the word register into the result
//   register. Throughput is one item per cycle while m_ready stays high,
//   set by the combinational table decode between the two registers.
//   Receiver stall: the result register holds; the word register still
//   takes a new item if it is empty or moves into a free result slot, so up
//   to two items are held while m_ready is low, then s_ready drops.
//   Reset (aresetn low, synchronous) empties both stages; no item is lost
//   or emitted out of reset. No configuration, no internal state beyond
//   the two pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_primary_and_special_decode_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mpsd_pkg::WORD_W-1:0]   s_instr_word,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mpsd_pkg::ID_W-1:0]          m_instr_id,
    output logic                               m_is_valid,
    output logic                               m_alt_form
);

    logic                        word_vld_reg;
    logic                        word_vld_next;
    logic [mpsd_pkg::WORD_W-1:0] word_reg;
    logic                        res_vld_reg;
    logic                        res_vld_next;
    mpsd_pkg::dec_result_t       res_reg;
    mpsd_pkg::dec_result_t       dec_res;
    logic                        res_load;
    logic                        word_load;

    mpsd_decode u_decode (
        .instr_word (word_reg),
        .result     (dec_res)
    );

    assign res_load  = word_vld_reg && (!res_vld_reg || m_ready);
    assign s_ready   = !word_vld_reg || res_load;
    assign word_load = s_valid && s_ready;

    always_comb begin
        word_vld_next = word_vld_reg;
        if (word_load) begin
            word_vld_next = 1'b1;
        end else if (res_load) begin
            word_vld_next = 1'b0;
        end
        res_vld_next = res_vld_reg;
        if (res_load) begin
            res_vld_next = 1'b1;
        end else if (m_ready) begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end else begin
            word_vld_reg <= word_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (word_load) begin
            word_reg <= s_instr_word;
        end
        if (res_load) begin
            res_reg <= dec_res;
        end
    end

    assign m_valid    = res_vld_reg;
    assign m_instr_id = res_reg.instr_id;
    assign m_is_valid = res_reg.is_valid;
    assign m_alt_form = res_reg.alt_form;

    a_valid_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_valid == (m_instr_id != mpsd_pkg::ID_INVALID)))
        else $error("is_valid disagrees with instr_id");

    a_alt_jalr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_alt_form) |-> (m_instr_id == mpsd_pkg::ID_JALR))
        else $error("alt_form set on non-jalr item");

    a_id_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_instr_id <= mpsd_pkg::ID_MAX))
        else $error("instr_id out of range");

    a_word_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (word_vld_reg && !res_load) |=> (word_vld_reg && $stable(word_reg)))
        else $error("stalled word register changed");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_vld_reg && !m_ready) |-> !res_load)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the primary/SPECIAL instruction decoder against a predictor built
// from its opcode and funct maps. Directed words hit the pseudo rewrites and
// the invalid opcodes, then random words mix SPECIAL, primary and raw
// patterns. Both channels idle at random, and the receiver holds off once
// for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mpsd_pkg::*;

    localparam int N_RANDOM    = 1675;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int SPECIAL_BASE = 53;

    // set bit n means opcode/funct n is assigned
    localparam logic [63:0] PRIMARY_USED = 64'hF7FF_FFFF_0FF0_FFFC;
    localparam logic [63:0] SPECIAL_USED = 64'hDD5F_FCFF_FFDF_BFDD;

    localparam logic [FLD_W-1:0] OPC_REGIMM = 6'd1;
    localparam logic [FLD_W-1:0] OPC_BEQ    = 6'd4;
    localparam logic [FLD_W-1:0] OPC_BNE    = 6'd5;
    localparam logic [FLD_W-1:0] OPC_COP0   = 6'd16;
    localparam logic [FLD_W-1:0] OPC_BEQL   = 6'd20;
    localparam logic [FLD_W-1:0] OPC_BNEL   = 6'd21;
    localparam logic [FLD_W-1:0] OPC_HOLE   = 6'd59;
    localparam logic [FLD_W-1:0] OPC_SD     = 6'd63;
    localparam logic [FLD_W-1:0] FN_SLL     = 6'd0;
    localparam logic [FLD_W-1:0] FN_HOLE    = 6'd1;
    localparam logic [FLD_W-1:0] FN_JALR    = 6'd9;
    localparam logic [FLD_W-1:0] FN_SUBU    = 6'd35;
    localparam logic [FLD_W-1:0] FN_OR      = 6'd37;
    localparam logic [FLD_W-1:0] FN_NOR     = 6'd39;
    localparam logic [FLD_W-1:0] FN_DSRA32  = 6'd63;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [WORD_W-1:0] s_instr_word = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ID_W-1:0]   m_instr_id;
    logic              m_is_valid;
    logic              m_alt_form;

    logic [WORD_W-1:0] word_q[$];
    dec_result_t       decode_q[$];
    dec_result_t       want_res;
    logic              in_took = 1'b0;

    int n_err = 0;
    int n_offered = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_invalid = 0;
    int n_pseudo = 0;
    int n_alt = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit held_once = 1'b0;

    mips_primary_and_special_decode_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_instr_word (s_instr_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_instr_id   (m_instr_id),
        .m_is_valid   (m_is_valid),
        .m_alt_form   (m_alt_form)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] enc(input logic [FLD_W-1:0] opc,
                                               input logic [REG_W-1:0] rs,
                                               input logic [REG_W-1:0] rt,
                                               input logic [REG_W-1:0] rd,
                                               input logic [FLD_W-1:0] fn);
        return {opc, rs, rt, rd, 5'd0, fn};
    endfunction

    // ids are dense: count of assigned codes up to and including this one, plus SPECIAL_BASE for funct codes
    function automatic dec_result_t decode_word(input logic [WORD_W-1:0] w);
        logic [FLD_W-1:0] opc;
        logic [FLD_W-1:0] fn;
        logic [REG_W-1:0] rs;
        logic [REG_W-1:0] rt;
        logic [REG_W-1:0] rd;
        logic [63:0]      upto;
        logic [ID_W-1:0]  id;
        dec_result_t      r;
        opc  = w[31:26];
        rs   = w[25:21];
        rt   = w[20:16];
        rd   = w[15:11];
        fn   = w[5:0];
        id   = ID_INVALID;
        if (opc == OPC_SPECIAL) begin
            upto = (64'd2 << fn) - 64'd1;
            if (SPECIAL_USED[fn])
                id = ID_W'(SPECIAL_BASE + $countones(SPECIAL_USED & upto));
            if (w == '0) begin
                id = ID_NOP;
            end else if (rt == REG_ZERO) begin
                if (id == ID_OR)
                    id = ID_MOVE;
                else if (id == ID_NOR)
                    id = ID_NOT;
            end else if (id == ID_SUBU && rs == REG_ZERO) begin
                id = ID_NEGU;
            end
        end else begin
            upto = (64'd2 << opc) - 64'd1;
            if (PRIMARY_USED[opc])
                id = ID_W'($countones(PRIMARY_USED & upto));
            if (rt == REG_ZERO) begin
                if (id == ID_BEQ)
                    id = (rs == REG_ZERO) ? ID_B : ID_BEQZ;
                else if (id == ID_BNE)
                    id = ID_BNEZ;
            end
        end
        r.instr_id = id;
        r.is_valid = (id != ID_INVALID);
        r.alt_form = (id == ID_JALR) && (rd != REG_RA);
        return r;
    endfunction

    // mostly structured words with register fields biased toward zero
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        int                sel;
        w   = $urandom;
        sel = $urandom_range(0, 9);
        if (sel <= 3) begin
            w[31:26] = OPC_SPECIAL;
            case ($urandom_range(0, 5))
                0: w[5:0] = FN_OR;
                1: w[5:0] = FN_NOR;
                2: w[5:0] = FN_SUBU;
                3: w[5:0] = FN_JALR;
                default: ;
            endcase
            if ($urandom_range(0, 9) < 3) w[20:16] = REG_ZERO;
            if ($urandom_range(0, 9) < 3) w[25:21] = REG_ZERO;
            if ($urandom_range(0, 9) < 2) w[15:11] = REG_RA;
        end else if (sel <= 7) begin
            w[31:26] = FLD_W'($urandom_range(1, 63));
            case ($urandom_range(0, 6))
                0: w[31:26] = OPC_BEQ;
                1: w[31:26] = OPC_BNE;
                2: w[31:26] = OPC_BEQL;
                3: w[31:26] = OPC_BNEL;
                default: ;
            endcase
            if ($urandom_range(0, 9) < 3) w[20:16] = REG_ZERO;
            if ($urandom_range(0, 9) < 3) w[25:21] = REG_ZERO;
        end else if (sel == 8 && $urandom_range(0, 3) == 0) begin
            w = '0;
        end
        return w;
    endfunction

    // input side: predict on every accepted item
    always @(posedge aclk) begin
        in_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            decode_q.push_back(decode_word(s_instr_word));
            n_accepted++;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_took)) begin
            if (word_q.size() != 0 &&
                ((n_offered >= 800 && n_offered < 1100) || $urandom_range(0, 99) >= 18)) begin
                s_valid      <= 1'b1;
                s_instr_word <= word_q.pop_front();
                n_offered++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_once && n_results >= 300) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (n_results >= 800 && n_results < 1100) ||
                           ($urandom_range(0, 99) >= 18);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (decode_q.size() == 0) begin
                $display("%0t: unexpected result id %0d valid %0b alt %0b",
                         $time, m_instr_id, m_is_valid, m_alt_form);
                n_err++;
            end else begin
                want_res = decode_q.pop_front();
                if (m_instr_id !== want_res.instr_id) begin
                    $display("%0t: instr_id expected %0d actual %0d",
                             $time, want_res.instr_id, m_instr_id);
                    n_err++;
                end
                if (m_is_valid !== want_res.is_valid) begin
                    $display("%0t: is_valid expected %0b actual %0b",
                             $time, want_res.is_valid, m_is_valid);
                    n_err++;
                end
                if (m_alt_form !== want_res.alt_form) begin
                    $display("%0t: alt_form expected %0b actual %0b",
                             $time, want_res.alt_form, m_alt_form);
                    n_err++;
                end
                if (!want_res.is_valid) n_invalid++;
                if (want_res.instr_id >= ID_B) n_pseudo++;
                if (want_res.alt_form) n_alt++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("mips_primary_and_special_decode_core verification failed");
            $finish;
        end
    end

    initial begin
        word_q.push_back(32'h0000_0000);
        word_q.push_back(32'hFFFF_FFFF);
        word_q.push_back(enc(OPC_BEQ, 5'd0, 5'd0, 5'd3, 6'd17));
        word_q.push_back(enc(OPC_BEQ, 5'd5, 5'd0, 5'd0, 6'd0));
        word_q.push_back(enc(OPC_BEQ, 5'd0, 5'd7, 5'd0, 6'd0));
        word_q.push_back(enc(OPC_BNE, 5'd3, 5'd0, 5'd0, 6'd0));
        word_q.push_back(enc(OPC_BNE, 5'd3, 5'd9, 5'd0, 6'd0));
        word_q.push_back(enc(OPC_BEQL, 5'd0, 5'd0, 5'd0, 6'd0));
        word_q.push_back(enc(OPC_BNEL, 5'd4, 5'd0, 5'd0, 6'd0));
        word_q.push_back(enc(OPC_SPECIAL, 5'd4, 5'd0, 5'd2, FN_OR));
        word_q.push_back(enc(OPC_SPECIAL, 5'd4, 5'd0, 5'd2, FN_NOR));
        word_q.push_back(enc(OPC_SPECIAL, 5'd4, 5'd6, 5'd2, FN_OR));
        word_q.push_back(enc(OPC_SPECIAL, 5'd0, 5'd6, 5'd2, FN_SUBU));
        word_q.push_back(enc(OPC_SPECIAL, 5'd0, 5'd0, 5'd2, FN_SUBU));
        word_q.push_back(enc(OPC_SPECIAL, 5'd1, 5'd6, 5'd2, FN_SUBU));
        word_q.push_back(enc(OPC_SPECIAL, 5'd8, 5'd0, REG_RA, FN_JALR));
        word_q.push_back(enc(OPC_SPECIAL, 5'd8, 5'd0, 5'd5, FN_JALR));
        word_q.push_back(enc(OPC_REGIMM, 5'd2, 5'd1, 5'd0, 6'd4));
        word_q.push_back(enc(OPC_COP0, 5'd4, 5'd12, 5'd0, 6'd0));
        word_q.push_back(enc(OPC_SPECIAL, 5'd1, 5'd2, 5'd3, FN_HOLE));
        word_q.push_back(enc(OPC_SPECIAL, 5'd0, 5'd0, 5'd0, FN_SLL) | 32'h0000_0140);
        word_q.push_back(enc(OPC_HOLE, 5'd31, 5'd31, 5'd31, 6'd63));
        word_q.push_back(enc(OPC_SD, 5'd0, 5'd0, 5'd0, 6'd0));
        word_q.push_back(enc(OPC_SPECIAL, 5'd31, 5'd31, 5'd31, FN_DSRA32));
        word_q.push_back(enc(OPC_SPECIAL, 5'd0, 5'd0, 5'd0, FN_OR));
        for (int k = 0; k < N_RANDOM; k++)
            word_q.push_back(random_word());

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (word_q.size() != 0 || s_valid || decode_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Decoded %0d words into %0d results: %0d invalid, %0d pseudo forms,",
                 n_accepted, n_results, n_invalid, n_pseudo);
        $display("%0d jalr with a non-ra link, one long receiver hold, %0d errors.",
                 n_alt, n_err);
        if (n_err == 0)
            $display("mips_primary_and_special_decode_core verification clean");
        else
            $display("mips_primary_and_special_decode_core verification failed");
        $finish;
    end

endmodule

// ===== mips_primary_and_special_decode_core.f =====
design/mpsd_pkg.sv
design/mpsd_decode.sv
design/mips_primary_and_special_decode_core.sv
verif/tb.sv
